// File: src/password_lock_controller_defines.svh
// assertion macros shared by the lock controller rtl
// depends on a clk and an active-low rst_n in the scope of each use
`ifndef PASSWORD_LOCK_CONTROLLER_DEFINES_SVH
`define PASSWORD_LOCK_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every edge out of reset
`define PLC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("lock controller check failed");

// implication checked at every edge out of reset
`define PLC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lock controller check failed");

`else

`define PLC_ASSERT(lbl, prop)
`define PLC_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

// File: src/plc_pkg.sv
`timescale 1ns / 1ps
// constants and codes for the combination lock controller
// no dependencies
package plc_pkg;

    // password geometry
    localparam int PASSWORD_LEN = 5;
    localparam int IDX_W        = (PASSWORD_LEN > 1) ? $clog2(PASSWORD_LEN) : 1;
    // two banks: stored password and first entry, swapped on a confirmed set
    localparam int MEM_AW       = IDX_W + 1;
    localparam int MEM_DEPTH    = 2 ** MEM_AW;

    // link codes
    localparam logic [7:0] READY_IN   = 8'h20;
    localparam logic [7:0] READY_OUT  = 8'h10;
    localparam logic [7:0] SYM_OPEN   = 8'h2A;  // '*'
    localparam logic [7:0] SYM_CHANGE = 8'h2B;  // '+'

    // modes
    localparam logic [2:0] MODE_SET    = 3'd0;
    localparam logic [2:0] MODE_MENU   = 3'd2;
    localparam logic [2:0] MODE_OPEN   = 3'd3;
    localparam logic [2:0] MODE_CHANGE = 3'd4;
    localparam logic [2:0] MODE_LOCK   = 3'd5;
    localparam logic [2:0] MODE_DOOR   = 3'd6;
    localparam logic [2:0] MODE_WAIT   = 3'd7;

    // register indexes
    localparam logic [1:0] CFG_MAX_TRIALS    = 2'd0;
    localparam logic [1:0] CFG_OPEN_TICKS    = 2'd1;
    localparam logic [1:0] CFG_LOCKOUT_TICKS = 2'd2;

    // register reset values
    localparam logic [3:0]  MAX_TRIALS_RST    = 4'd3;
    localparam logic [15:0] OPEN_TICKS_RST    = 16'd15000;
    localparam logic [15:0] LOCKOUT_TICKS_RST = 16'd60000;

    // reply queue
    localparam int MAX_RESULTS = 3;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW     = FIFO_AW + 1;

    // one reply word as queued
    typedef struct packed {
        logic [7:0] reply_byte;
        logic       motor_on;
        logic       buzzer_on;
        logic [3:0] fail_leds;
        logic       last;
    } reply_t;

endpackage

// File: src/password_lock_controller.sv
`timescale 1ns / 1ps
// combination lock controller: password memory, mode sequencer, reply queue
// depends on plc_pkg and password_lock_controller_defines.svh
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tuser = command, s_tdata = data_byte
// m_*       out  m_tvalid/m_tready  m_tdata = reply word, m_tlast = last
// cfg_*     in   cfg_wr_en          cfg_index, cfg_wdata
//
// one input word per cycle, each handled by a single byte compare or countdown
// step; the password memory read is prefetched at the next digit index
// a word yields up to three replies, queued in an eight-entry fifo; s_tready
// is low while fewer than three fifo slots are free
// reset clears the control state at once; the password banks need no sweep,
// as each entry is written before it is read
`include "password_lock_controller_defines.svh"

module password_lock_controller
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] command: 0 link byte, 1 ms tick
    // reply words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [7:0] reply_byte, [8] motor_on,
                                    // [9] buzzer_on, [13:10] fail_leds
    output logic        m_tlast,    // last
    // register writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);
    import plc_pkg::*;

    // configuration
    logic [3:0]  max_trials_reg;
    logic [15:0] open_ticks_reg;
    logic [15:0] lockout_ticks_reg;

    // control state
    logic [2:0]       mode_reg, mode_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             confirm_reg, confirm_next;
    logic             mismatch_reg, mismatch_next;
    logic             bank_reg, bank_next;       // bank holding the stored password
    logic [3:0]       trial_reg, trial_next;
    logic [15:0]      count_reg, count_next;
    logic             motor_reg, motor_next;
    logic             buzzer_reg, buzzer_next;
    logic [3:0]       leds_reg, leds_next;

    // password memory
    logic [7:0]        pw_mem [MEM_DEPTH];
    logic [7:0]        rd_q_reg;
    logic              mem_we;
    logic [MEM_AW-1:0] wr_addr;
    logic [MEM_AW-1:0] rd_addr;
    logic              rd_bank;

    // step results
    logic       accept;
    logic [1:0] push_cnt;
    logic [7:0] res_byte [MAX_RESULTS];
    logic       mm;
    logic       idx_last;
    logic [3:0] trial_inc;

    // reply fifo
    reply_t             fifo_mem [FIFO_DEPTH];
    reply_t             head;
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] fill_reg;
    logic               pop;

    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = (fill_reg <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS));

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_trials_reg    <= MAX_TRIALS_RST;
            open_ticks_reg    <= OPEN_TICKS_RST;
            lockout_ticks_reg <= LOCKOUT_TICKS_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_MAX_TRIALS:    max_trials_reg    <= cfg_wdata[3:0];
                CFG_OPEN_TICKS:    open_ticks_reg    <= cfg_wdata;
                CFG_LOCKOUT_TICKS: lockout_ticks_reg <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // mode sequencer: one word per cycle while s_tready is high
    always_comb
    begin
        mode_next     = mode_reg;
        idx_next      = idx_reg;
        confirm_next  = confirm_reg;
        mismatch_next = mismatch_reg;
        bank_next     = bank_reg;
        trial_next    = trial_reg;
        count_next    = count_reg;
        motor_next    = motor_reg;
        buzzer_next   = buzzer_reg;
        leds_next     = leds_reg;
        mem_we        = 1'b0;
        push_cnt      = 2'd0;
        res_byte[0]   = 8'h00;
        res_byte[1]   = 8'h00;
        res_byte[2]   = 8'h00;

        mm        = mismatch_reg || (s_tdata != rd_q_reg);
        idx_last  = (idx_reg == IDX_W'(PASSWORD_LEN - 1));
        trial_inc = trial_reg + 4'd1;

        if (accept)
        begin
            if (s_tuser)
            begin
                // millisecond tick: only counts down in door or lockout mode
                if (mode_reg == MODE_DOOR || mode_reg == MODE_LOCK)
                begin
                    if (count_reg <= 16'd1)
                    begin
                        count_next  = 16'd0;
                        motor_next  = 1'b0;
                        buzzer_next = 1'b0;
                        mode_next   = MODE_MENU;
                        res_byte[0] = READY_OUT;
                        push_cnt    = 2'd1;
                    end
                    else
                    begin
                        count_next = count_reg - 16'd1;
                    end
                end
            end
            else
            begin
                unique case (mode_reg) inside
                    MODE_WAIT:
                    begin
                        // no password can be stored before the ready byte
                        if (s_tdata == READY_IN)
                        begin
                            mode_next   = MODE_SET;
                            res_byte[0] = {5'b0, MODE_SET};
                            push_cnt    = 2'd1;
                        end
                    end
                    MODE_SET:
                    begin
                        if (!confirm_reg)
                        begin
                            // first entry goes to the spare bank
                            mem_we   = 1'b1;
                            idx_next = idx_reg + 1'b1;
                            if (idx_last)
                            begin
                                idx_next      = '0;
                                confirm_next  = 1'b1;
                                mismatch_next = 1'b0;
                            end
                        end
                        else
                        begin
                            idx_next      = idx_reg + 1'b1;
                            mismatch_next = mm;
                            if (idx_last)
                            begin
                                idx_next      = '0;
                                confirm_next  = 1'b0;
                                mismatch_next = 1'b0;
                                res_byte[0]   = {7'b0, !mm};
                                push_cnt      = 2'd1;
                                if (!mm)
                                begin
                                    // spare bank becomes the stored password
                                    bank_next   = !bank_reg;
                                    mode_next   = MODE_MENU;
                                    res_byte[1] = READY_OUT;
                                    push_cnt    = 2'd2;
                                end
                            end
                        end
                    end
                    MODE_MENU:
                    begin
                        if (s_tdata == SYM_OPEN)
                        begin
                            mode_next = MODE_OPEN;
                        end
                        else if (s_tdata == SYM_CHANGE)
                        begin
                            mode_next = MODE_CHANGE;
                        end
                        else
                        begin
                            res_byte[0] = READY_OUT;
                            push_cnt    = 2'd1;
                        end
                        idx_next      = '0;
                        mismatch_next = 1'b0;
                    end
                    MODE_OPEN, MODE_CHANGE:
                    begin
                        idx_next      = idx_reg + 1'b1;
                        mismatch_next = mm;
                        if (idx_last)
                        begin
                            idx_next      = '0;
                            mismatch_next = 1'b0;
                            res_byte[0]   = {7'b0, !mm};
                            if (mm)
                            begin
                                // wrong entry: count it, maybe lock out
                                trial_next  = trial_inc;
                                if (trial_inc > leds_reg)
                                begin
                                    leds_next = trial_inc;
                                end
                                res_byte[1] = {5'b0, mode_reg};
                                if (trial_inc >= max_trials_reg)
                                begin
                                    trial_next  = 4'd0;
                                    mode_next   = MODE_LOCK;
                                    count_next  = lockout_ticks_reg;
                                    buzzer_next = 1'b1;
                                    res_byte[1] = {5'b0, MODE_LOCK};
                                end
                                push_cnt = 2'd2;
                            end
                            else if (mode_reg == MODE_OPEN)
                            begin
                                trial_next  = 4'd0;
                                leds_next   = 4'd0;
                                res_byte[1] = {5'b0, MODE_OPEN};
                                res_byte[2] = READY_OUT;
                                push_cnt    = 2'd3;
                                motor_next  = 1'b1;
                                count_next  = open_ticks_reg;
                                mode_next   = MODE_DOOR;
                            end
                            else
                            begin
                                trial_next   = 4'd0;
                                leds_next    = 4'd0;
                                mode_next    = MODE_SET;
                                confirm_next = 1'b0;
                                res_byte[1]  = {5'b0, MODE_SET};
                                push_cnt     = 2'd2;
                            end
                        end
                    end
                    default:
                    begin
                        // door or lockout: link bytes are ignored
                    end
                endcase
            end
        end
    end

    // control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_WAIT;
            idx_reg      <= '0;
            confirm_reg  <= 1'b0;
            mismatch_reg <= 1'b0;
            bank_reg     <= 1'b0;
            trial_reg    <= 4'd0;
            count_reg    <= 16'd0;
            motor_reg    <= 1'b0;
            buzzer_reg   <= 1'b0;
            leds_reg     <= 4'd0;
        end
        else
        begin
            mode_reg     <= mode_next;
            idx_reg      <= idx_next;
            confirm_reg  <= confirm_next;
            mismatch_reg <= mismatch_next;
            bank_reg     <= bank_next;
            trial_reg    <= trial_next;
            count_reg    <= count_next;
            motor_reg    <= motor_next;
            buzzer_reg   <= buzzer_next;
            leds_reg     <= leds_next;
        end
    end

    // prefetch address: spare bank while confirming, stored bank otherwise
    assign rd_bank = (mode_next == MODE_SET && confirm_next) ? !bank_next : bank_next;
    assign rd_addr = {rd_bank, idx_next};
    assign wr_addr = {!bank_reg, idx_reg};

    // password memory with write-to-read forwarding
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pw_mem[wr_addr] <= s_tdata;
        end
        if (mem_we && wr_addr == rd_addr)
        begin
            rd_q_reg <= s_tdata;
        end
        else
        begin
            rd_q_reg <= pw_mem[rd_addr];
        end
    end

    // reply fifo storage
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RESULTS; k++)
        begin
            if (2'(k) < push_cnt)
            begin
                fifo_mem[wr_ptr_reg + FIFO_AW'(k)] <= '{
                    reply_byte: res_byte[k],
                    motor_on:   motor_next,
                    buzzer_on:  buzzer_next,
                    fail_leds:  leds_next,
                    last:       (2'(k) == push_cnt - 2'd1)
                };
            end
        end
    end

    // reply fifo pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(pop);
            fill_reg   <= fill_reg + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
        end
    end

    // reply word out
    assign head     = fifo_mem[rd_ptr_reg];
    assign m_tvalid = (fill_reg != '0);
    assign m_tdata  = {2'b00, head.fail_leds, head.buzzer_on, head.motor_on,
                       head.reply_byte};
    assign m_tlast  = head.last;

    // checks
    `PLC_ASSERT(a_fill_bound, fill_reg <= FIFO_CW'(FIFO_DEPTH))
    `PLC_ASSERT_IMP(a_room_on_accept, accept, fill_reg <= FIFO_CW'(FIFO_DEPTH - MAX_RESULTS))
    `PLC_ASSERT(a_motor_buzzer_excl, !(motor_reg && buzzer_reg))
    `PLC_ASSERT_IMP(a_motor_in_door, motor_reg, mode_reg == MODE_DOOR)
    `PLC_ASSERT_IMP(a_buzzer_in_lock, buzzer_reg, mode_reg == MODE_LOCK)
    `PLC_ASSERT(a_idx_range, idx_reg <= IDX_W'(PASSWORD_LEN - 1))

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// self-checking bench for the combination lock controller: directed words, then
// mode-aware random words under several register settings and idling patterns
// depends on plc_pkg and password_lock_controller
module tb;
    import plc_pkg::*;

    localparam logic [7:0] NO_PASSWORD   = 8'hFF;
    localparam logic [7:0] SYM_DASH      = 8'h2D;  // '-', unfinished menu branch
    localparam int         SETTLE_CYCLES = 16;
    localparam int         STALL_LIMIT   = 2000;

    // shadow of the lock state and queue of the replies it predicts
    class lock_scoreboard;
        logic [3:0]       trials_limit;
        logic [15:0]      open_len;
        logic [15:0]      lockout_len;
        logic [2:0]       lock_mode;
        logic [IDX_W-1:0] digit_pos;
        logic             confirming;
        logic             entry_wrong;
        logic [3:0]       wrong_tries;
        logic [3:0]       leds_lit;
        logic [15:0]      ticks_left;
        logic             motor_run;
        logic             buzzer_run;
        logic [7:0]       draft_code [PASSWORD_LEN];
        logic [7:0]       saved_code [PASSWORD_LEN];
        reply_t           expected_replies [$];
        int               error_count;

        function new();
            trials_limit = MAX_TRIALS_RST;
            open_len     = OPEN_TICKS_RST;
            lockout_len  = LOCKOUT_TICKS_RST;
            lock_mode    = MODE_WAIT;
            digit_pos    = '0;
            confirming   = 1'b0;
            entry_wrong  = 1'b0;
            wrong_tries  = 4'd0;
            leds_lit     = 4'd0;
            ticks_left   = 16'd0;
            motor_run    = 1'b0;
            buzzer_run   = 1'b0;
            error_count  = 0;
            foreach (saved_code[i])
            begin
                saved_code[i] = NO_PASSWORD;
                draft_code[i] = 8'h00;
            end
        endfunction

        function logic counting_down();
            return lock_mode == MODE_DOOR || lock_mode == MODE_LOCK;
        endfunction

        function void write_reg(logic [1:0] index, logic [15:0] value);
            case (index)
                CFG_MAX_TRIALS:    trials_limit = value[3:0];
                CFG_OPEN_TICKS:    open_len = value;
                CFG_LOCKOUT_TICKS: lockout_len = value;
                default: ;
            endcase
        endfunction

        // accepted input word: advance the shadow state, queue its replies
        function void note_word(logic cmd, logic [7:0] data);
            logic [7:0] replies [MAX_RESULTS];
            int         n;
            reply_t     want;
            n = 0;
            if (cmd)
            begin
                // tick only matters while a countdown runs
                if (counting_down())
                begin
                    if (ticks_left <= 16'd1)
                    begin
                        ticks_left = 16'd0;
                        motor_run  = 1'b0;
                        buzzer_run = 1'b0;
                        lock_mode  = MODE_MENU;
                        replies[n] = READY_OUT;
                        n = n + 1;
                    end
                    else
                        ticks_left = ticks_left - 16'd1;
                end
            end
            else
            begin
                if (digit_pos >= PASSWORD_LEN)
                    digit_pos = '0;
                case (lock_mode) inside
                    MODE_WAIT:
                    begin
                        if (data == READY_IN)
                        begin
                            if (saved_code[0] != NO_PASSWORD)
                            begin
                                lock_mode  = MODE_MENU;
                                replies[n] = {5'b0, MODE_MENU};
                                n = n + 1;
                                replies[n] = READY_OUT;
                                n = n + 1;
                            end
                            else
                            begin
                                lock_mode  = MODE_SET;
                                replies[n] = {5'b0, MODE_SET};
                                n = n + 1;
                            end
                        end
                    end
                    MODE_SET:
                    begin
                        // first pass fills the draft, second pass confirms it
                        if (!confirming)
                        begin
                            draft_code[digit_pos] = data;
                            if (digit_pos == IDX_W'(PASSWORD_LEN - 1))
                            begin
                                digit_pos   = '0;
                                confirming  = 1'b1;
                                entry_wrong = 1'b0;
                            end
                            else
                                digit_pos = digit_pos + 1'b1;
                        end
                        else
                        begin
                            if (data != draft_code[digit_pos])
                                entry_wrong = 1'b1;
                            if (digit_pos == IDX_W'(PASSWORD_LEN - 1))
                            begin
                                digit_pos  = '0;
                                confirming = 1'b0;
                                replies[n] = {7'b0, !entry_wrong};
                                n = n + 1;
                                if (!entry_wrong)
                                begin
                                    foreach (saved_code[i])
                                        saved_code[i] = draft_code[i];
                                    lock_mode  = MODE_MENU;
                                    replies[n] = READY_OUT;
                                    n = n + 1;
                                end
                                entry_wrong = 1'b0;
                            end
                            else
                                digit_pos = digit_pos + 1'b1;
                        end
                    end
                    MODE_MENU:
                    begin
                        if (data == SYM_OPEN)
                            lock_mode = MODE_OPEN;
                        else if (data == SYM_CHANGE)
                            lock_mode = MODE_CHANGE;
                        else
                        begin
                            replies[n] = READY_OUT;
                            n = n + 1;
                        end
                        digit_pos   = '0;
                        entry_wrong = 1'b0;
                    end
                    MODE_OPEN, MODE_CHANGE:
                    begin
                        if (data != saved_code[digit_pos])
                            entry_wrong = 1'b1;
                        if (digit_pos == IDX_W'(PASSWORD_LEN - 1))
                        begin
                            digit_pos  = '0;
                            replies[n] = {7'b0, !entry_wrong};
                            n = n + 1;
                            if (entry_wrong)
                            begin
                                // leds hold the highest count since the last good entry
                                wrong_tries = wrong_tries + 4'd1;
                                if (wrong_tries > leds_lit)
                                    leds_lit = wrong_tries;
                                if (wrong_tries >= trials_limit)
                                begin
                                    wrong_tries = 4'd0;
                                    lock_mode   = MODE_LOCK;
                                    ticks_left  = lockout_len;
                                    buzzer_run  = 1'b1;
                                end
                                replies[n] = {5'b0, lock_mode};
                                n = n + 1;
                            end
                            else if (lock_mode == MODE_OPEN)
                            begin
                                wrong_tries = 4'd0;
                                leds_lit    = 4'd0;
                                replies[n]  = {5'b0, MODE_OPEN};
                                n = n + 1;
                                replies[n]  = READY_OUT;
                                n = n + 1;
                                motor_run   = 1'b1;
                                ticks_left  = open_len;
                                lock_mode   = MODE_DOOR;
                            end
                            else
                            begin
                                wrong_tries = 4'd0;
                                leds_lit    = 4'd0;
                                lock_mode   = MODE_SET;
                                confirming  = 1'b0;
                                replies[n]  = {5'b0, MODE_SET};
                                n = n + 1;
                            end
                            entry_wrong = 1'b0;
                        end
                        else
                            digit_pos = digit_pos + 1'b1;
                    end
                    default: ;
                endcase
            end
            // all replies of one word carry the state after it
            for (int k = 0; k < n; k++)
            begin
                want.reply_byte = replies[k];
                want.motor_on   = motor_run;
                want.buzzer_on  = buzzer_run;
                want.fail_leds  = leds_lit;
                want.last       = (k == n - 1);
                expected_replies.push_back(want);
            end
        endfunction

        // accepted reply word against the oldest prediction
        function void check_reply(logic [15:0] word, logic tlast);
            reply_t want;
            if (expected_replies.size() == 0)
            begin
                $error("reply word %h arrived with nothing expected", word);
                error_count++;
                return;
            end
            want = expected_replies.pop_front();
            if (word[7:0] !== want.reply_byte)
            begin
                $error("reply_byte: expected %h, got %h", want.reply_byte, word[7:0]);
                error_count++;
            end
            if (word[8] !== want.motor_on)
            begin
                $error("motor_on: expected %b, got %b", want.motor_on, word[8]);
                error_count++;
            end
            if (word[9] !== want.buzzer_on)
            begin
                $error("buzzer_on: expected %b, got %b", want.buzzer_on, word[9]);
                error_count++;
            end
            if (word[13:10] !== want.fail_leds)
            begin
                $error("fail_leds: expected %0d, got %0d", want.fail_leds, word[13:10]);
                error_count++;
            end
            if (word[15:14] !== 2'b00)
            begin
                $error("tdata padding: expected 0, got %b", word[15:14]);
                error_count++;
            end
            if (tlast !== want.last)
            begin
                $error("last: expected %b, got %b", want.last, tlast);
                error_count++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_MAX_TRIALS;
    logic [15:0] cfg_wdata = 16'h0000;

    lock_scoreboard sb;
    int send_idle  = 0;
    int recv_stall = 0;
    int quiet_cycles = 0;

    password_lock_controller dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // reply side: check accepted words, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_reply(m_tdata, m_tlast);
            m_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // offer one word after a random gap, note it once accepted
    task automatic send_word(input logic cmd, input logic [7:0] data);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_word(cmd, data);
    endtask

    // mostly well-formed words for the current mode; finishes any countdown
    task automatic drive_random(input int target);
        int         done;
        int         roll;
        logic       cmd;
        logic [7:0] data;
        logic       ignored;
        done = 0;
        while (done < target || sb.counting_down())
        begin
            roll = $urandom_range(99);
            cmd  = 1'b0;
            data = 8'($urandom_range(255));
            case (sb.lock_mode) inside
                MODE_DOOR, MODE_LOCK:
                    cmd = (roll < 90);
                MODE_MENU:
                begin
                    if (roll < 40)
                        data = SYM_OPEN;
                    else if (roll < 65)
                        data = SYM_CHANGE;
                    else if (roll < 75)
                        data = SYM_DASH;
                    else if (roll < 85)
                        cmd = 1'b1;
                end
                MODE_SET:
                begin
                    if (roll < 5)
                        cmd = 1'b1;
                    else if (sb.confirming && roll < 95)
                        data = sb.draft_code[sb.digit_pos];
                end
                MODE_OPEN, MODE_CHANGE:
                begin
                    if (roll < 5)
                        cmd = 1'b1;
                    else if (roll < 90)
                        data = sb.saved_code[sb.digit_pos];
                end
                default: ;
            endcase
            ignored = cmd ? !sb.counting_down() : sb.counting_down();
            send_word(cmd, data);
            if (!ignored)
                done++;
        end
    endtask

    // hold the sender until every predicted reply is in, then let it settle
    task automatic wait_replies();
        s_tvalid <= 1'b0;
        while (sb.expected_replies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // single register write while the block is idle
    task automatic write_cfg(input logic [1:0] index, input logic [15:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(index, value);
    endtask

    // one register setting with its own idling pattern
    task automatic run_phase(input logic [3:0] trials, input logic [15:0] open_t,
                             input logic [15:0] lock_t, input int idle, input int stall,
                             input int count);
        wait_replies();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MAX_TRIALS;
        cfg_wdata <= {12'h000, trials};
        @(posedge clk);
        cfg_index <= CFG_OPEN_TICKS;
        cfg_wdata <= open_t;
        @(posedge clk);
        cfg_index <= CFG_LOCKOUT_TICKS;
        cfg_wdata <= lock_t;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(CFG_MAX_TRIALS, {12'h000, trials});
        sb.write_reg(CFG_OPEN_TICKS, open_t);
        sb.write_reg(CFG_LOCKOUT_TICKS, lock_t);
        send_idle  = idle;
        recv_stall = stall;
        drive_random(count);
    endtask

    initial
    begin
        logic [7:0] code [PASSWORD_LEN];
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (code[i])
            code[i] = 8'h7F + 8'(i);
        code[0] = 8'hFF;
        code[1] = 8'h00;
        code[2] = READY_IN;

        // before ready: a tick and a stray byte do nothing
        send_word(1'b1, 8'hA5);
        send_word(1'b0, 8'h55);
        send_word(1'b0, READY_IN);
        // set with a wrong confirmation, then set properly
        foreach (code[i])
            send_word(1'b0, code[i]);
        foreach (code[i])
            send_word(1'b0, (i == 0) ? ~code[i] : code[i]);
        repeat (2)
            foreach (code[i])
                send_word(1'b0, code[i]);
        // short open time so the door countdown stays brief
        wait_replies();
        write_cfg(CFG_OPEN_TICKS, 16'd10);
        // unknown menu symbol, then a correct open entry
        send_word(1'b0, SYM_DASH);
        send_word(1'b0, SYM_OPEN);
        foreach (code[i])
            send_word(1'b0, code[i]);
        // open time runs out
        drive_random(0);

        run_phase(4'd1, 16'd1, 16'd1, 0, 0, 45);
        run_phase(4'd15, 16'd20, 16'd30, 45, 0, 45);
        run_phase(4'($urandom_range(2, 6)), 16'($urandom_range(1, 40)),
                  16'($urandom_range(1, 40)), 0, 45, 45);
        run_phase(4'd0, 16'd0, 16'd0, 18, 18, 35);
        run_phase(4'd4, 16'd32, 16'd48, 0, 0, 25);
        run_phase(4'($urandom_range(1, 15)), 16'($urandom_range(1, 12)),
                  16'($urandom_range(1, 12)), 18, 18, 25);

        wait_replies();
        if (sb.error_count == 0 && sb.expected_replies.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/plc_pkg.sv
src/password_lock_controller.sv
tb/tb.sv
